// ----- hw/rtl/mlcr_pkg.sv -----
// mlcr_pkg: shared types and constants of the midpoint line color rasterizer
// used by mlcr_ctrl, mlcr_datapath and the top level; depends on nothing

package mlcr_pkg;

  // color channel and quotient widths
  localparam int unsigned COLOR_BITS   = 8;
  localparam int unsigned QUOT_BITS    = COLOR_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(QUOT_BITS);

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_SETUP,
    ST_MUL,
    ST_STEP,
    ST_DIV,
    ST_EMIT
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic abs_en;
    logic setup;
    logic mul;
    logic step;
    logic div;
    logic emit;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic active;
    logic last;
  } dp_status_t;

endpackage

// ----- hw/rtl/mlcr_ctrl.sv -----
// mlcr_ctrl: sequencing state machine and output valid of the rasterizer
// depends on mlcr_pkg for state, command and status types

module mlcr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 kind_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  mlcr_pkg::dp_status_t status_i,
  output mlcr_pkg::dp_cmd_t    cmd_o,
  output mlcr_pkg::state_e     state_o
);

  mlcr_pkg::state_e                       state_q, state_d;
  logic [mlcr_pkg::DIV_CNT_BITS-1:0]      cnt_q, cnt_d;
  logic                                   out_valid_q, out_valid_d;
  logic                                   out_free;
  logic                                   div_done;

  assign out_free = !out_valid_q || !out_stall_i;
  assign div_done = (cnt_q == mlcr_pkg::DIV_CNT_BITS'(mlcr_pkg::QUOT_BITS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mlcr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == mlcr_pkg::KIND_LOAD) begin
            state_d = mlcr_pkg::ST_ABS;
          end else if (status_i.active) begin
            state_d = mlcr_pkg::ST_STEP;
          end
        end
      end
      mlcr_pkg::ST_ABS:   state_d = mlcr_pkg::ST_SETUP;
      mlcr_pkg::ST_SETUP: state_d = mlcr_pkg::ST_MUL;
      mlcr_pkg::ST_MUL:   state_d = mlcr_pkg::ST_EMIT;
      mlcr_pkg::ST_STEP:  state_d = mlcr_pkg::ST_DIV;
      mlcr_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = mlcr_pkg::ST_EMIT;
        end
      end
      mlcr_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = mlcr_pkg::ST_IDLE;
        end
      end
      default: state_d = mlcr_pkg::ST_IDLE;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = (state_q == mlcr_pkg::ST_IDLE) && in_valid_i &&
                   (kind_i == mlcr_pkg::KIND_LOAD);
    cmd_o.abs_en = (state_q == mlcr_pkg::ST_ABS);
    cmd_o.setup  = (state_q == mlcr_pkg::ST_SETUP);
    cmd_o.mul    = (state_q == mlcr_pkg::ST_MUL);
    cmd_o.step   = (state_q == mlcr_pkg::ST_STEP);
    cmd_o.div    = (state_q == mlcr_pkg::ST_DIV);
    cmd_o.emit   = (state_q == mlcr_pkg::ST_EMIT) && out_free;
    in_stall_o   = (state_q != mlcr_pkg::ST_IDLE);
  end

  // divider iteration count and output valid
  always_comb begin
    cnt_d       = (state_q == mlcr_pkg::ST_DIV) ? cnt_q + 1'b1 : '0;
    out_valid_d = cmd_o.emit ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mlcr_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign state_o     = state_q;

endmodule

// ----- hw/rtl/mlcr_datapath.sv -----
// mlcr_datapath: line setup, midpoint stepper, color numerators, three-lane
// restoring divider and output word register; depends on mlcr_pkg

module mlcr_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mlcr_pkg::dp_cmd_t                     cmd_i,
  output mlcr_pkg::dp_status_t                  status_o,
  input  logic signed [COORD_BITS-1:0]          start_x_i,
  input  logic signed [COORD_BITS-1:0]          start_y_i,
  input  logic signed [COORD_BITS-1:0]          end_x_i,
  input  logic signed [COORD_BITS-1:0]          end_y_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]       start_red_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]       start_green_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]       start_blue_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]       end_red_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]       end_green_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]       end_blue_i,
  output logic signed [COORD_BITS-1:0]          point_x_o,
  output logic signed [COORD_BITS-1:0]          point_y_o,
  output logic [mlcr_pkg::COLOR_BITS-1:0]       red_o,
  output logic [mlcr_pkg::COLOR_BITS-1:0]       green_o,
  output logic [mlcr_pkg::COLOR_BITS-1:0]       blue_o,
  output logic                                  last_o
);

  localparam int CB  = COORD_BITS;
  localparam int DXW = COORD_BITS + 1;
  localparam int DW  = COORD_BITS + 3;
  localparam int QB  = mlcr_pkg::QUOT_BITS;
  localparam int CW  = mlcr_pkg::COLOR_BITS;
  localparam int NW  = COORD_BITS + mlcr_pkg::COLOR_BITS;
  localparam int NCH = 3;

  // line state
  logic signed [CB-1:0]  cur_x_q, cur_y_q;
  logic signed [DXW-1:0] dx_q, dy_q;
  logic [CB-1:0]         adx_q, ady_q;
  logic                  x_neg_q, y_neg_q, x_major_q;
  logic signed [DW-1:0]  decision_q, inc_str_q, inc_diag_q;
  logic [CB-1:0]         len_q, step_idx_q;
  logic                  active_q, active_d;

  // color lanes
  logic [CW-1:0]         col_start_q [NCH];
  logic [CW-1:0]         col_end_q   [NCH];
  logic [CW-1:0]         col_start_in [NCH];
  logic [CW-1:0]         col_end_in   [NCH];
  logic [NW-1:0]         num_q  [NCH];
  logic [NW-1:0]         num_nx [NCH];
  logic [NW-1:0]         rem_q  [NCH];
  logic [QB-1:0]         quo_q  [NCH];
  logic [NW:0]           trial  [NCH];
  logic [NW-1:0]         dsh_q;

  // output word
  logic signed [CB-1:0]  point_x_q, point_y_q;
  logic [CW-1:0]         color_q [NCH];
  logic                  last_q;

  // setup and step combinational values
  logic [DXW-1:0]        neg_dx, neg_dy;
  logic                  x_major_w;
  logic [CB-1:0]         major_w, minor_w;
  logic signed [DW-1:0]  two_minor_w;
  logic                  move_minor;
  logic [CB-1:0]         x_inc, y_inc;
  logic [CB-1:0]         step_idx_nx;
  logic                  last_w;

  assign col_start_in[0] = start_red_i;
  assign col_start_in[1] = start_green_i;
  assign col_start_in[2] = start_blue_i;
  assign col_end_in[0]   = end_red_i;
  assign col_end_in[1]   = end_green_i;
  assign col_end_in[2]   = end_blue_i;

  // absolute differences
  assign neg_dx = -dx_q;
  assign neg_dy = -dy_q;

  // major axis selection and decision setup
  assign x_major_w   = (adx_q >= ady_q);
  assign major_w     = x_major_w ? adx_q : ady_q;
  assign minor_w     = x_major_w ? ady_q : adx_q;
  assign two_minor_w = $signed({2'b00, minor_w, 1'b0});

  // midpoint step
  assign move_minor  = !decision_q[DW-1] && (|decision_q);
  assign x_inc       = x_neg_q ? '1 : CB'(1);
  assign y_inc       = y_neg_q ? '1 : CB'(1);
  assign step_idx_nx = step_idx_q + 1'b1;
  assign last_w      = (step_idx_q >= len_q);

  // numerator update and divider trial subtract per lane
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      num_nx[c] = num_q[c] +
                  NW'($signed({1'b0, col_end_q[c]} - {1'b0, col_start_q[c]}));
      trial[c]  = {1'b0, rem_q[c]} - {1'b0, dsh_q};
    end
  end

  // active flag
  always_comb begin
    active_d = active_q;
    if (cmd_i.setup) begin
      active_d = (major_w != '0);
    end else if (cmd_i.step) begin
      active_d = (step_idx_nx != len_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // line registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q <= start_x_i;
      cur_y_q <= start_y_i;
      dx_q    <= DXW'(end_x_i) - DXW'(start_x_i);
      dy_q    <= DXW'(end_y_i) - DXW'(start_y_i);
      for (int c = 0; c < NCH; c++) begin
        col_start_q[c] <= col_start_in[c];
        col_end_q[c]   <= col_end_in[c];
      end
    end
    if (cmd_i.abs_en) begin
      adx_q   <= dx_q[DXW-1] ? neg_dx[CB-1:0] : dx_q[CB-1:0];
      ady_q   <= dy_q[DXW-1] ? neg_dy[CB-1:0] : dy_q[CB-1:0];
      x_neg_q <= dx_q[DXW-1];
      y_neg_q <= dy_q[DXW-1];
    end
    if (cmd_i.setup) begin
      x_major_q  <= x_major_w;
      decision_q <= two_minor_w - $signed({3'b000, major_w});
      inc_str_q  <= two_minor_w;
      inc_diag_q <= two_minor_w - $signed({2'b00, major_w, 1'b0});
      len_q      <= major_w;
      step_idx_q <= '0;
    end
    if (cmd_i.step) begin
      if (x_major_q || move_minor) begin
        cur_x_q <= cur_x_q + x_inc;
      end
      if (!x_major_q || move_minor) begin
        cur_y_q <= cur_y_q + y_inc;
      end
      decision_q <= decision_q + (move_minor ? inc_diag_q : inc_str_q);
      step_idx_q <= step_idx_nx;
    end
  end

  // color numerators and restoring divider lanes
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int c = 0; c < NCH; c++) begin
        num_q[c] <= NW'(col_start_q[c]) * NW'(len_q);
        quo_q[c] <= col_start_q[c];
      end
    end
    if (cmd_i.step) begin
      for (int c = 0; c < NCH; c++) begin
        num_q[c] <= num_nx[c];
        rem_q[c] <= num_nx[c];
      end
      dsh_q <= NW'(len_q) << (QB - 1);
    end
    if (cmd_i.div) begin
      for (int c = 0; c < NCH; c++) begin
        if (!trial[c][NW]) begin
          rem_q[c] <= trial[c][NW-1:0];
        end
        quo_q[c] <= {quo_q[c][QB-2:0], !trial[c][NW]};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      point_x_q <= cur_x_q;
      point_y_q <= cur_y_q;
      last_q    <= last_w;
      for (int c = 0; c < NCH; c++) begin
        color_q[c] <= quo_q[c];
      end
    end
  end

  assign status_o.active = active_q;
  assign status_o.last   = last_w;

  assign point_x_o = point_x_q;
  assign point_y_o = point_y_q;
  assign red_o     = color_q[0];
  assign green_o   = color_q[1];
  assign blue_o    = color_q[2];
  assign last_o    = last_q;

endmodule

// ----- hw/rtl/midpoint_line_color_rasterizer.sv -----
// midpoint_line_color_rasterizer: top level joining mlcr_ctrl and mlcr_datapath
// depends on mlcr_pkg, mlcr_ctrl.sv and mlcr_datapath.sv
//
// Usage: the input channel takes one word per line command. A load word
// (kind 0) carries both endpoints and both RGB colors and returns the line's
// first point in the start color. A step word (kind 1) returns the next point
// along the major axis with its color floor((s*(len-i)+e*i)/len) per channel;
// last_o marks the final point. A step with no line left is consumed and
// returns no word.
// Timing: a load word passes through the difference at its accepting edge, then
// absolute value, setup, start-color multiply and output, and the input takes
// the next word once the output register is written. A step word passes
// through the stepper, the restoring divider that runs the three color
// channels as parallel lanes, and the output state; the divider sets the pace
// of steps. One word is in flight at a time.
// The output register lets the next input word be accepted while a result
// still waits; a stalled receiver holds the block only when a new result is
// ready for the occupied output register.
// Reset: asynchronous, active low; comes up idle, no line, no output word.

module midpoint_line_color_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic signed [COORD_BITS-1:0]      start_x_i,
  input  logic signed [COORD_BITS-1:0]      start_y_i,
  input  logic signed [COORD_BITS-1:0]      end_x_i,
  input  logic signed [COORD_BITS-1:0]      end_y_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]   start_red_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]   start_green_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]   start_blue_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]   end_red_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]   end_green_i,
  input  logic [mlcr_pkg::COLOR_BITS-1:0]   end_blue_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_BITS-1:0]      point_x_o,
  output logic signed [COORD_BITS-1:0]      point_y_o,
  output logic [mlcr_pkg::COLOR_BITS-1:0]   red_o,
  output logic [mlcr_pkg::COLOR_BITS-1:0]   green_o,
  output logic [mlcr_pkg::COLOR_BITS-1:0]   blue_o,
  output logic                              last_o
);

  mlcr_pkg::dp_cmd_t    cmd;
  mlcr_pkg::dp_status_t status;
  mlcr_pkg::state_e     state;

  // controller
  mlcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  // datapath
  mlcr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .start_red_i   (start_red_i),
    .start_green_i (start_green_i),
    .start_blue_i  (start_blue_i),
    .end_red_i     (end_red_i),
    .end_green_i   (end_green_i),
    .end_blue_i    (end_blue_i),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_o        (last_o)
  );

  // an accepted load keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (kind_i == mlcr_pkg::KIND_LOAD)) |=> in_stall_o)
    else $error("load accepted but block not busy");

  // the point being emitted is the last one exactly when the line went inactive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == mlcr_pkg::ST_EMIT) |-> (status.last != status.active))
    else $error("last flag and active flag disagree");

  // a new output word appears only out of the emit state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state) == mlcr_pkg::ST_EMIT))
    else $error("output word valid without emit");

  // a step with no line left is consumed and leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (kind_i == mlcr_pkg::KIND_STEP) && !status.active)
      |=> !in_stall_o)
    else $error("idle step did not complete at once");

endmodule
